>>> design/pwbd_pkg.sv
`default_nettype none

package pwbd_pkg;

  // Number of white/black bit pairs that make one code.
  localparam int BITS_PER_CODE = 8;
  localparam int BIT_IDX_W = (BITS_PER_CODE > 1) ? $clog2(BITS_PER_CODE) : 1;

  // Field widths.
  localparam int TIME_W = 32;
  localparam int CODE_W = 8;
  localparam int VEL_W = 32;
  localparam int PERIOD_W = TIME_W + 1;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Input word kinds.
  typedef enum logic {
    ACT_EDGE = 1'b0,
    ACT_READ = 1'b1
  } action_t;

  // Status codes returned by a read.
  typedef enum logic [1:0] {
    STATUS_NONE        = 2'd0,
    STATUS_IN_PROGRESS = 2'd1,
    STATUS_SUCCESS     = 2'd2
  } status_t;

  // One read request as classified by the front.
  typedef struct packed {
    status_t               status;
    logic [CODE_W-1:0]     code_value;
    logic [PERIOD_W-1:0]   period;
  } entry_t;

endpackage

`default_nettype wire

>>> design/pwbd_front.sv
`default_nettype none

module pwbd_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_accept,
  input  wire logic                          in_action,
  input  wire logic [pwbd_pkg::TIME_W-1:0]   in_timestamp,
  output pwbd_pkg::entry_t                   entry,
  output logic                               push
);
  import pwbd_pkg::*;

  logic                  in_black_phase;
  logic [BIT_IDX_W-1:0]  bit_index;
  logic                  capturing;
  logic                  code_ready;
  logic [TIME_W-1:0]     last_edge_time;
  logic [TIME_W-1:0]     current_white_width;
  logic [CODE_W-1:0]     decoded_bits;
  logic [PERIOD_W-1:0]   final_period;

  logic [TIME_W-1:0]     width;
  logic                  new_bit;
  logic                  last_bit;
  logic                  is_read;

  // Width since the previous edge, modulo 2^32, and the bit it gives.
  assign width    = in_timestamp - last_edge_time;
  assign new_bit  = (current_white_width > width);
  assign last_bit = (bit_index == BIT_IDX_W'(BITS_PER_CODE - 1));
  assign is_read  = (in_action == ACT_READ);

  // A read request becomes a queue entry carrying everything the back needs.
  always_comb begin
    push             = in_accept && is_read;
    entry.period     = final_period;
    entry.code_value = '0;
    if (code_ready) begin
      entry.status     = STATUS_SUCCESS;
      entry.code_value = decoded_bits;
    end else if (capturing) begin
      entry.status = STATUS_IN_PROGRESS;
    end else begin
      entry.status = STATUS_NONE;
    end
  end

  // Capture state, updated by edge events and cleared by a successful read.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_black_phase      <= 1'b0;
      bit_index           <= '0;
      capturing           <= 1'b0;
      code_ready          <= 1'b0;
      last_edge_time      <= '0;
      current_white_width <= '0;
      decoded_bits        <= '0;
      final_period        <= '0;
    end else if (in_accept) begin
      if (is_read) begin
        code_ready <= 1'b0;
      end else if (capturing) begin
        last_edge_time <= in_timestamp;
        if (!in_black_phase) begin
          current_white_width <= width;
          in_black_phase      <= 1'b1;
        end else begin
          decoded_bits   <= {decoded_bits[CODE_W-2:0], new_bit};
          in_black_phase <= 1'b0;
          if (last_bit) begin
            bit_index    <= '0;
            code_ready   <= 1'b1;
            capturing    <= 1'b0;
            final_period <= PERIOD_W'(current_white_width) + PERIOD_W'(width);
          end else begin
            bit_index <= bit_index + 1'b1;
          end
        end
      end else if (!code_ready) begin
        // First edge starts a new capture.
        capturing      <= 1'b1;
        decoded_bits   <= '0;
        last_edge_time <= in_timestamp;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/pwbd_queue.sv
`default_nettype none

module pwbd_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire pwbd_pkg::entry_t   push_entry,
  input  wire logic               pop,
  output pwbd_pkg::entry_t        head,
  output logic                    full,
  output logic                    empty
);
  import pwbd_pkg::*;

  entry_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr;
  logic [QUEUE_PTR_W-1:0]   rd_ptr;
  logic [QUEUE_CNT_W-1:0]   count;

  assign full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/pwbd_back.sv
`default_nettype none

module pwbd_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [pwbd_pkg::VEL_W-1:0]  scaled_length,
  input  wire pwbd_pkg::entry_t            head,
  input  wire logic                        empty,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output pwbd_pkg::status_t                out_status,
  output logic [pwbd_pkg::CODE_W-1:0]      out_code_value,
  output logic [pwbd_pkg::VEL_W-1:0]       out_velocity
);
  import pwbd_pkg::*;

  localparam int STEP_W = $clog2(VEL_W);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t               state;
  logic [STEP_W-1:0]    step;
  logic [PERIOD_W-1:0]  divisor;
  logic [PERIOD_W-1:0]  rem;
  logic [VEL_W-1:0]     quo;

  logic [PERIOD_W:0]    rem_sh;
  logic                 fits;
  logic [PERIOD_W:0]    rem_sub;

  // One restoring division step per cycle.
  assign rem_sh  = {rem, quo[VEL_W-1]};
  assign fits    = (rem_sh >= {1'b0, divisor});
  assign rem_sub = rem_sh - {1'b0, divisor};

  assign pop       = (state == ST_IDLE) && !empty;
  assign out_valid = (state == ST_OUT);

  // Sequencer: take an entry, divide if needed, hold the result until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!empty) begin
            out_status     <= head.status;
            out_code_value <= head.code_value;
            step           <= '0;
            divisor        <= head.period;
            rem            <= '0;
            quo            <= scaled_length;
            if (head.status != STATUS_SUCCESS) begin
              out_velocity <= '0;
              state        <= ST_OUT;
            end else if (head.period == '0) begin
              out_velocity <= '1;
              state        <= ST_OUT;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem  <= fits ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
          quo  <= {quo[VEL_W-2:0], fits};
          step <= step + 1'b1;
          if (step == STEP_W'(VEL_W - 1)) begin
            out_velocity <= {quo[VEL_W-2:0], fits};
            state        <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/pulse_width_barcode_decoder.sv
`default_nettype none

// Pulse-width barcode decoder. Each input word is either a sensor edge
// (tuser = 0, timestamp in tdata) or a read request (tuser = 1). The first
// edge starts a capture; later edges measure alternating white and black
// widths, and each pair gives one bit, 1 when white is wider, first bit
// most significant. A read returns one word: status in tuser, and in tdata
// the code byte and the velocity, scaled_length divided by the last bit
// period. The input side keeps taking words, edges and reads alike, while
// a two-word queue between classification and division has room. A
// successful read with a nonzero period is loaded, passed through the
// bit-serial divider and then presented; any other read is loaded and
// presented directly. Sustained read throughput is set by that divider.
module pulse_width_barcode_decoder (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wen,
  input  wire logic [31:0]  cfg_wdata,       // scaled_length
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,    // [31:0] timestamp
  input  wire logic         s_axis_tuser,    // [0] action
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [39:0]       m_axis_tdata,    // [7:0] code_value, [39:8] velocity
  output logic [1:0]        m_axis_tuser     // [1:0] status
);
  import pwbd_pkg::*;

  logic [VEL_W-1:0]     scaled_length;
  logic                 in_accept;
  logic                 push;
  logic                 pop;
  logic                 full;
  logic                 empty;
  entry_t               push_entry;
  entry_t               head;
  status_t              out_status;
  logic [CODE_W-1:0]    out_code_value;
  logic [VEL_W-1:0]     out_velocity;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      scaled_length <= '0;
    end else if (cfg_wen) begin
      scaled_length <= cfg_wdata;
    end
  end

  assign s_axis_tready = !full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  pwbd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_accept    (in_accept),
    .in_action    (s_axis_tuser),
    .in_timestamp (s_axis_tdata),
    .entry        (push_entry),
    .push         (push)
  );

  pwbd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  pwbd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .scaled_length  (scaled_length),
    .head           (head),
    .empty          (empty),
    .pop            (pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_status     (out_status),
    .out_code_value (out_code_value),
    .out_velocity   (out_velocity)
  );

  // Output word packing.
  assign m_axis_tdata = {out_velocity, out_code_value};
  assign m_axis_tuser = out_status;

endmodule

`default_nettype wire
